@@ rtl/mghs_pkg.sv @@
package mghs_pkg;

    localparam int unsigned MAX_RESULTS = 10;
    localparam int unsigned CNT_W       = 4;

    localparam logic signed [15:0] RST_HOME_TARGET   = 16'sd23040;
    localparam logic signed [15:0] RST_HOME_CURRENT  = 16'sd500;
    localparam logic        [14:0] RST_HOME_TOL      = 15'd256;
    localparam logic        [31:0] RST_HOME_TIMEOUT  = 32'd6000;

    typedef enum logic [2:0] {
        MODE_OFFLINE = 3'd0,
        MODE_IDLE    = 3'd1,
        MODE_CALIB   = 3'd2,
        MODE_RUNNING = 3'd3,
        MODE_FAULT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        RK_STATUS  = 3'd0,
        RK_RESTORE = 3'd1,
        RK_ZERO    = 3'd2,
        RK_HOME    = 3'd3,
        RK_FULL    = 3'd4,
        RK_DISABLE = 3'd5
    } t_rkind;

    typedef enum logic [1:0] {
        SC_OK          = 2'd0,
        SC_BAD_INDEX   = 2'd1,
        SC_NOT_RUNNING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        IK_REPORT  = 2'd0,
        IK_TICK    = 2'd1,
        IK_SET_ONE = 2'd2,
        IK_SET_ALL = 2'd3
    } t_ikind;

    typedef enum logic [2:0] {
        REG_HOME_TARGET  = 3'd0,
        REG_HOME_CURRENT = 3'd1,
        REG_HOME_TOL     = 3'd2,
        REG_HOME_TIMEOUT = 3'd3,
        REG_FAULT_EN     = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DISPATCH,
        C_CAL_WALK,
        C_CAL_END,
        C_ENT_WALK,
        C_FLT_WALK,
        C_SET_ONE,
        C_SET_ALL,
        C_STATUS
    } t_ctl_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        motor_index;
        logic              link_online;
        logic              motor_fault;
        logic              motor_running;
        logic              motor_ready;
        logic signed [15:0] angle_feedback;
        logic signed [15:0] present_current;
        logic signed [15:0] position_request;
        logic signed [15:0] speed_request;
        logic signed [15:0] current_request;
        logic [31:0]       time_ms;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [3:0]        target_motor;
        logic signed [15:0] position_target;
        logic signed [15:0] speed_target;
        logic signed [15:0] current_target;
        logic [2:0]        group_state;
        logic [1:0]        status_code;
        logic              last_result;
    } t_out_beat;

    typedef struct packed {
        logic       load_item;
        logic       write_report;
        logic       set_mode;
        t_mode      mode;
        logic       set_homed;
        logic       calib_entry;
        logic       save_cur;
        logic       mark_homed;
        logic       load_out;
        t_rkind     out_kind;
        t_status    out_code;
        logic [3:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        t_ikind     kind;
        logic [3:0] item_idx;
        logic       idx_ok;
        t_mode      mode;
        t_mode      nx_simple;
        logic       online_any;
        logic       any_err;
        logic       timeout;
        logic       cal_done;
        logic       run;
        logic       ready;
        logic       done_bit;
        logic       near;
    } t_dp_sts;

endpackage

@@ rtl/mghs_ctrl.sv @@
module mghs_ctrl #(
    parameter int unsigned MOTORS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mghs_pkg::t_dp_cmd o_cmd,
    input  mghs_pkg::t_dp_sts i_sts
);
    import mghs_pkg::*;

    t_ctl_state       r_state, n_state;
    logic [3:0]       r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_status          r_code, n_code;
    logic             r_out_valid, n_out_valid;
    logic             r_cal_done, n_cal_done;

    logic   walking, want, emit, adv, last_idx, slot_free;
    t_rkind kind;

    always_comb begin
        walking = 1'b1;
        want    = 1'b1;
        kind    = RK_STATUS;
        unique case (r_state)
            C_CAL_WALK: begin
                want = i_sts.run && !i_sts.done_bit && (i_sts.timeout || i_sts.near);
                kind = i_sts.timeout ? RK_RESTORE : RK_ZERO;
            end
            C_ENT_WALK: begin
                want = i_sts.ready;
                kind = RK_HOME;
            end
            C_FLT_WALK: kind = RK_DISABLE;
            C_SET_ONE:  kind = RK_FULL;
            C_SET_ALL:  kind = RK_FULL;
            C_STATUS:   kind = RK_STATUS;
            default: begin
                walking = 1'b0;
                want    = 1'b0;
            end
        endcase
        slot_free = !r_out_valid || i_out_ready;
        last_idx  = (r_idx == 4'(MOTORS - 1));
        emit      = walking && want && (r_cnt < CNT_W'(MAX_RESULTS));
        adv       = walking && (!emit || slot_free);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_in_valid) begin
                    n_state = C_DISPATCH;
                end
            end
            C_DISPATCH: begin
                unique case (i_sts.kind)
                    IK_REPORT: n_state = C_STATUS;
                    IK_TICK: begin
                        if (i_sts.mode == MODE_CALIB) begin
                            priority if (!i_sts.online_any) n_state = C_STATUS;
                            else if (i_sts.any_err)         n_state = C_FLT_WALK;
                            else                             n_state = C_CAL_WALK;
                        end else if (i_sts.nx_simple == i_sts.mode) begin
                            n_state = C_STATUS;
                        end else if (i_sts.nx_simple == MODE_CALIB) begin
                            n_state = C_ENT_WALK;
                        end else if (i_sts.nx_simple == MODE_FAULT) begin
                            n_state = C_FLT_WALK;
                        end else begin
                            n_state = C_STATUS;
                        end
                    end
                    IK_SET_ONE: n_state = (i_sts.idx_ok && i_sts.mode == MODE_RUNNING) ?
                                          C_SET_ONE : C_STATUS;
                    IK_SET_ALL: n_state = (i_sts.mode == MODE_RUNNING) ? C_SET_ALL : C_STATUS;
                endcase
            end
            C_CAL_WALK: begin
                if (adv && last_idx) begin
                    n_state = C_CAL_END;
                end
            end
            C_CAL_END: n_state = C_STATUS;
            C_ENT_WALK, C_FLT_WALK, C_SET_ALL: begin
                if (adv && last_idx) begin
                    n_state = C_STATUS;
                end
            end
            C_SET_ONE: begin
                if (adv) begin
                    n_state = C_STATUS;
                end
            end
            C_STATUS: begin
                if (adv) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mode     = MODE_OFFLINE;
        o_cmd.out_kind = kind;
        o_cmd.out_code = r_code;
        o_cmd.idx      = (r_state == C_SET_ONE) ? i_sts.item_idx : r_idx;
        o_cmd.load_out = emit && adv;
        n_idx          = adv ? 4'(r_idx + 4'd1) : r_idx;
        n_cnt          = (emit && adv) ? CNT_W'(r_cnt + 1'b1) : r_cnt;
        n_code         = r_code;
        n_cal_done     = r_cal_done;
        unique case (r_state)
            C_IDLE: begin
                o_cmd.load_item = i_in_valid;
                n_idx           = '0;
                n_cnt           = '0;
                n_code          = SC_OK;
            end
            C_DISPATCH: begin
                unique case (i_sts.kind)
                    IK_REPORT: begin
                        o_cmd.write_report = i_sts.idx_ok;
                        n_code             = i_sts.idx_ok ? SC_OK : SC_BAD_INDEX;
                    end
                    IK_TICK: begin
                        if (i_sts.mode == MODE_CALIB) begin
                            priority if (!i_sts.online_any) begin
                                o_cmd.set_mode = 1'b1;
                                o_cmd.mode     = MODE_OFFLINE;
                            end else if (i_sts.any_err) begin
                                o_cmd.set_mode = 1'b1;
                                o_cmd.mode     = MODE_FAULT;
                            end else begin
                                n_cal_done = i_sts.cal_done;
                            end
                        end else if (i_sts.nx_simple != i_sts.mode) begin
                            o_cmd.set_mode    = 1'b1;
                            o_cmd.mode        = i_sts.nx_simple;
                            o_cmd.calib_entry = (i_sts.nx_simple == MODE_CALIB);
                        end
                    end
                    IK_SET_ONE: begin
                        priority if (!i_sts.idx_ok)              n_code = SC_BAD_INDEX;
                        else if (i_sts.mode != MODE_RUNNING)     n_code = SC_NOT_RUNNING;
                        else                                     n_code = SC_OK;
                    end
                    IK_SET_ALL: begin
                        n_code = (i_sts.mode != MODE_RUNNING) ? SC_NOT_RUNNING : SC_OK;
                    end
                endcase
            end
            C_CAL_WALK: o_cmd.mark_homed = adv && want;
            C_ENT_WALK: o_cmd.save_cur = adv && want;
            C_CAL_END: begin
                if (r_cal_done) begin
                    o_cmd.set_mode  = 1'b1;
                    o_cmd.mode      = MODE_RUNNING;
                    o_cmd.set_homed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (emit && adv) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_code      <= SC_OK;
            r_out_valid <= 1'b0;
            r_cal_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
            r_cal_done  <= n_cal_done;
        end
    end

    assign o_in_ready  = (r_state == C_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/mghs_dpath.sv @@
module mghs_dpath #(
    parameter int unsigned MOTORS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    input  mghs_pkg::t_in_beat i_in_data,
    input  mghs_pkg::t_dp_cmd  i_cmd,
    output mghs_pkg::t_dp_sts  o_sts,
    output mghs_pkg::t_out_beat o_out_data
);
    import mghs_pkg::*;

    localparam int unsigned IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    logic signed [15:0] r_home_target;
    logic signed [15:0] r_home_current;
    logic [14:0]        r_home_tol;
    logic [31:0]        r_home_timeout;
    logic               r_fault_en;

    t_in_beat           r_item;
    t_mode              r_mode;
    logic               r_homed;
    logic [MOTORS-1:0]  r_homed_mask;
    logic [31:0]        r_calib_start;
    logic [15:0]        r_saved [MOTORS];
    logic [3:0]         r_flags [MOTORS];
    logic [15:0]        r_angle [MOTORS];
    logic [15:0]        r_current [MOTORS];
    t_out_beat          r_out, n_out;

    logic [MOTORS-1:0]  online_vec, fault_vec, run_vec;
    logic [IW-1:0]      sel, rep_sel;
    logic [15:0]        diff;
    logic [16:0]        mag;
    logic               online_any, any_err;
    t_mode              nx_simple;
    logic               cfg_wr;

    assign sel     = i_cmd.idx[IW-1:0];
    assign rep_sel = r_item.motor_index[IW-1:0];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        for (int i = 0; i < MOTORS; i++) begin
            online_vec[i] = r_flags[i][0];
            fault_vec[i]  = r_flags[i][1];
            run_vec[i]    = r_flags[i][2];
        end
        online_any = |online_vec;
        any_err    = r_fault_en && (|fault_vec);
        unique case (r_mode)
            MODE_IDLE: begin
                priority if (!online_any) nx_simple = MODE_OFFLINE;
                else if (any_err)         nx_simple = MODE_FAULT;
                else if (|run_vec)        nx_simple = r_homed ? MODE_RUNNING : MODE_CALIB;
                else                      nx_simple = MODE_IDLE;
            end
            MODE_RUNNING: begin
                priority if (!online_any) nx_simple = MODE_OFFLINE;
                else if (any_err)         nx_simple = MODE_FAULT;
                else if (!(|run_vec))     nx_simple = MODE_IDLE;
                else                      nx_simple = MODE_RUNNING;
            end
            default: begin
                priority if (!online_any) nx_simple = MODE_OFFLINE;
                else if (any_err)         nx_simple = MODE_FAULT;
                else                      nx_simple = MODE_IDLE;
            end
        endcase
        diff = r_angle[sel] - r_home_target;
        mag  = diff[15] ? (17'd0 - {diff[15], diff}) : {1'b0, diff};
    end

    always_comb begin
        o_sts.kind       = t_ikind'(r_item.kind);
        o_sts.item_idx   = r_item.motor_index;
        o_sts.idx_ok     = ({1'b0, r_item.motor_index} < 5'(MOTORS));
        o_sts.mode       = r_mode;
        o_sts.nx_simple  = nx_simple;
        o_sts.online_any = online_any;
        o_sts.any_err    = any_err;
        o_sts.timeout    = ((r_item.time_ms - r_calib_start) >= r_home_timeout);
        o_sts.cal_done   = (|run_vec) && ((run_vec & ~r_homed_mask) == '0);
        o_sts.run        = r_flags[sel][2];
        o_sts.ready      = r_flags[sel][3];
        o_sts.done_bit   = r_homed_mask[sel];
        o_sts.near       = (mag <= {2'b00, r_home_tol});
    end

    always_comb begin
        n_out                 = '0;
        n_out.result_kind     = i_cmd.out_kind;
        n_out.target_motor    = i_cmd.idx;
        n_out.group_state     = r_mode;
        unique case (i_cmd.out_kind)
            RK_STATUS: begin
                n_out.target_motor = '0;
                n_out.status_code  = i_cmd.out_code;
                n_out.last_result  = 1'b1;
            end
            RK_RESTORE, RK_ZERO: n_out.current_target = r_saved[sel];
            RK_HOME: begin
                n_out.position_target = r_home_target;
                n_out.current_target  = r_home_current;
            end
            RK_FULL: begin
                n_out.position_target = r_item.position_request;
                n_out.speed_target    = r_item.speed_request;
                n_out.current_target  = r_item.current_request;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_HOME_TARGET:  prdata = {{16{r_home_target[15]}}, r_home_target};
            REG_HOME_CURRENT: prdata = {{16{r_home_current[15]}}, r_home_current};
            REG_HOME_TOL:     prdata = {17'd0, r_home_tol};
            REG_HOME_TIMEOUT: prdata = r_home_timeout;
            REG_FAULT_EN:     prdata = {31'd0, r_fault_en};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_target  <= RST_HOME_TARGET;
            r_home_current <= RST_HOME_CURRENT;
            r_home_tol     <= RST_HOME_TOL;
            r_home_timeout <= RST_HOME_TIMEOUT;
            r_fault_en     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_HOME_TARGET:  r_home_target  <= pwdata[15:0];
                REG_HOME_CURRENT: r_home_current <= pwdata[15:0];
                REG_HOME_TOL:     r_home_tol     <= pwdata[14:0];
                REG_HOME_TIMEOUT: r_home_timeout <= pwdata;
                REG_FAULT_EN:     r_fault_en     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFFLINE;
            r_homed       <= 1'b0;
            r_homed_mask  <= '0;
            r_calib_start <= '0;
            for (int i = 0; i < MOTORS; i++) begin
                r_flags[i]   <= '0;
                r_angle[i]   <= '0;
                r_current[i] <= '0;
            end
        end else begin
            if (i_cmd.set_mode) begin
                r_mode <= i_cmd.mode;
            end
            if (i_cmd.set_homed) begin
                r_homed <= 1'b1;
            end
            if (i_cmd.calib_entry) begin
                r_homed_mask  <= '0;
                r_calib_start <= r_item.time_ms;
            end else if (i_cmd.mark_homed) begin
                r_homed_mask[sel] <= 1'b1;
            end
            if (i_cmd.write_report) begin
                r_flags[rep_sel]   <= {r_item.motor_ready, r_item.motor_running,
                                       r_item.motor_fault, r_item.link_online};
                r_angle[rep_sel]   <= r_item.angle_feedback;
                r_current[rep_sel] <= r_item.present_current;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.save_cur) begin
            r_saved[sel] <= r_current[sel];
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ rtl/motor_group_homing_supervisor.sv @@
// Channel   Direction  Handshake                Beat
// input     in         i_in_valid / o_in_ready  mghs_pkg::t_in_beat
// output    out        o_out_valid / i_out_ready mghs_pkg::t_out_beat
// config    in         APB psel/penable/pwrite  32-bit registers at 4*i
//
// A report is dispatched after acceptance; its status beat is loaded in the status state that follows.
// A tick with no state change goes from dispatch straight to the status beat; one with an
// entry or fault walk passes over the motor records first; a calibration walk adds an end step.
// A running all-motor setpoint walks every motor; a single one or a refused one does not walk.
// Output stalls hold the walk; a new item is taken once the status beat is loaded.
// Reset is synchronous and active low and needs no clearing pass.
module motor_group_homing_supervisor #(
    parameter int unsigned MOTORS = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mghs_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mghs_pkg::t_out_beat  o_out_data
);
    import mghs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;

    mghs_ctrl #(.MOTORS(MOTORS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mghs_dpath #(.MOTORS(MOTORS)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

@@ rtl/mghs_checker.sv @@
module mghs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                pready,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mghs_pkg::t_out_beat o_out_data
);
    import mghs_pkg::*;

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last_result |-> o_out_data.result_kind == RK_STATUS)
        else $error("final beat is not a status beat");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_full_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == RK_FULL |->
        o_out_data.group_state == MODE_RUNNING)
        else $error("setpoint passed outside running");

endmodule

bind motor_group_homing_supervisor mghs_checker u_mghs_checker (.*);

@@ dv/tb_motor_group_homing_supervisor.sv @@
module tb_motor_group_homing_supervisor;
    import mghs_pkg::*;

    localparam int unsigned NMOT = 9;
    localparam int unsigned F_ON = 0;
    localparam int unsigned F_FLT = 1;
    localparam int unsigned F_RUN = 2;
    localparam int unsigned F_RDY = 3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_beat          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_beat         o_out_data;

    t_in_beat          send_q[$];
    t_out_beat         beats_due[$];
    int                errors = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              hold_go = 1'b0;
    logic              hold_seen = 1'b0;
    int                hold_cnt = 0;

    // Predicted block state and register copies.
    logic [15:0]       cfg_target;
    logic [15:0]       cfg_current;
    logic [14:0]       cfg_tol;
    logic [31:0]       cfg_timeout;
    logic              cfg_fault_en;
    t_mode             mode;
    logic              homed;
    logic [15:0]       homed_mask;
    logic [31:0]       calib_start;
    logic [15:0]       held_lim[NMOT];
    logic              saved_valid[NMOT];
    logic [3:0]        flags[NMOT];
    logic [15:0]       angle[NMOT];
    logic [15:0]       cur_lim[NMOT];
    logic [31:0]       now_ms = 0;

    motor_group_homing_supervisor #(.MOTORS(NMOT)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void emit_beat(t_rkind k, int unsigned m, logic [15:0] p,
                                      logic [15:0] s, logic [15:0] c,
                                      t_status code, logic last);
        t_out_beat b;
        b.result_kind = k;
        b.target_motor = m[3:0];
        b.position_target = p;
        b.speed_target = s;
        b.current_target = c;
        b.group_state = mode;
        b.status_code = code;
        b.last_result = last;
        beats_due.push_back(b);
    endfunction

    function automatic logic any_flag(int unsigned f);
        for (int i = 0; i < NMOT; i++) begin
            if (flags[i][f]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic any_fault();
        return cfg_fault_en && any_flag(F_FLT);
    endfunction

    function automatic t_mode calib_step(logic [31:0] t);
        int          run_cnt;
        int          fin_cnt;
        logic        expired;
        logic [15:0] diff;
        int          mag;
        run_cnt = 0;
        fin_cnt = 0;
        if (!any_flag(F_ON)) begin
            return MODE_OFFLINE;
        end
        if (any_fault()) begin
            return MODE_FAULT;
        end
        expired = (t - calib_start) >= cfg_timeout;
        for (int i = 0; i < NMOT; i++) begin
            if (!flags[i][F_RUN]) begin
                continue;
            end
            run_cnt++;
            if (homed_mask[i]) begin
                fin_cnt++;
                continue;
            end
            if (expired) begin
                emit_beat(RK_RESTORE, i, '0, '0, held_lim[i], SC_OK, 1'b0);
                homed_mask[i] = 1'b1;
                continue;
            end
            diff = angle[i] - cfg_target;
            mag = $signed(diff);
            if (mag < 0) begin
                mag = -mag;
            end
            if (mag <= int'(cfg_tol)) begin
                emit_beat(RK_ZERO, i, '0, '0, held_lim[i], SC_OK, 1'b0);
                homed_mask[i] = 1'b1;
            end
        end
        if (run_cnt > 0 && fin_cnt >= run_cnt) begin
            homed = 1'b1;
            return MODE_RUNNING;
        end
        return MODE_CALIB;
    endfunction

    function automatic void tick_step(logic [31:0] t);
        t_mode nx;
        logic  online;
        online = any_flag(F_ON);
        case (mode)
            MODE_IDLE: begin
                if (!online) nx = MODE_OFFLINE;
                else if (any_fault()) nx = MODE_FAULT;
                else if (any_flag(F_RUN)) nx = homed ? MODE_RUNNING : MODE_CALIB;
                else nx = MODE_IDLE;
            end
            MODE_CALIB: begin
                nx = calib_step(t);
            end
            MODE_RUNNING: begin
                if (!online) nx = MODE_OFFLINE;
                else if (any_fault()) nx = MODE_FAULT;
                else if (!any_flag(F_RUN)) nx = MODE_IDLE;
                else nx = MODE_RUNNING;
            end
            default: begin
                if (!online) nx = MODE_OFFLINE;
                else nx = any_fault() ? MODE_FAULT : MODE_IDLE;
            end
        endcase
        if (nx != mode) begin
            mode = nx;
            if (nx == MODE_CALIB) begin
                homed_mask = '0;
                calib_start = t;
                for (int i = 0; i < NMOT; i++) begin
                    if (flags[i][F_RDY]) begin
                        held_lim[i] = cur_lim[i];
                        saved_valid[i] = 1'b1;
                        emit_beat(RK_HOME, i, cfg_target, '0, cfg_current, SC_OK, 1'b0);
                    end
                end
            end
            if (nx == MODE_FAULT) begin
                for (int i = 0; i < NMOT; i++) begin
                    emit_beat(RK_DISABLE, i, '0, '0, '0, SC_OK, 1'b0);
                end
            end
        end
    endfunction

    function automatic void predict_item(t_in_beat b);
        t_status code;
        code = SC_OK;
        case (t_ikind'(b.kind))
            IK_REPORT: begin
                if (b.motor_index < NMOT) begin
                    flags[b.motor_index] = {b.motor_ready, b.motor_running,
                                            b.motor_fault, b.link_online};
                    angle[b.motor_index] = b.angle_feedback;
                    cur_lim[b.motor_index] = b.present_current;
                end else begin
                    code = SC_BAD_INDEX;
                end
            end
            IK_TICK: begin
                tick_step(b.time_ms);
            end
            IK_SET_ONE: begin
                if (b.motor_index >= NMOT) code = SC_BAD_INDEX;
                else if (mode != MODE_RUNNING) code = SC_NOT_RUNNING;
                else emit_beat(RK_FULL, b.motor_index, b.position_request,
                               b.speed_request, b.current_request, SC_OK, 1'b0);
            end
            default: begin
                if (mode != MODE_RUNNING) begin
                    code = SC_NOT_RUNNING;
                end else begin
                    for (int i = 0; i < NMOT; i++) begin
                        emit_beat(RK_FULL, i, b.position_request, b.speed_request,
                                  b.current_request, SC_OK, 1'b0);
                    end
                end
            end
        endcase
        emit_beat(RK_STATUS, 0, '0, '0, '0, code, 1'b1);
    endfunction

    function automatic void queue_item(t_in_beat b);
        predict_item(b);
        send_q.push_back(b);
    endfunction

    function automatic void queue_report(int unsigned idx, logic on, logic flt, logic run,
                                         logic rdy, logic [15:0] ang, logic [15:0] cur);
        t_in_beat b;
        b = t_in_beat'({$urandom, $urandom, $urandom, $urandom});
        b.kind = IK_REPORT;
        b.motor_index = idx[3:0];
        b.link_online = on;
        b.motor_fault = flt;
        b.motor_running = run;
        b.motor_ready = rdy;
        b.angle_feedback = ang;
        b.present_current = cur;
        queue_item(b);
    endfunction

    function automatic void queue_tick(logic [31:0] t);
        t_in_beat b;
        b = t_in_beat'({$urandom, $urandom, $urandom, $urandom});
        b.kind = IK_TICK;
        b.time_ms = t;
        queue_item(b);
    endfunction

    function automatic void queue_set(t_ikind k, int unsigned idx, logic [15:0] p,
                                      logic [15:0] s, logic [15:0] c);
        t_in_beat b;
        b = t_in_beat'({$urandom, $urandom, $urandom, $urandom});
        b.kind = k;
        b.motor_index = idx[3:0];
        b.position_request = p;
        b.speed_request = s;
        b.current_request = c;
        queue_item(b);
    endfunction

    // A motor may only report running where a restore would read a written save.
    function automatic void queue_random_item();
        int unsigned pick;
        int unsigned idx;
        logic        run;
        logic        rdy;
        logic [15:0] ang;
        pick = $urandom_range(0, 99);
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NMOT, 15)
                                           : $urandom_range(0, NMOT - 1);
        if (pick < 45) begin
            run = $urandom_range(0, 99) < 60;
            rdy = $urandom_range(0, 99) < 80;
            if (idx < NMOT && run && !saved_valid[idx]
                && (mode == MODE_CALIB || !rdy)) begin
                run = 1'b0;
            end
            if ($urandom_range(0, 1)) begin
                ang = cfg_target + 16'($signed($urandom_range(0, 2 * cfg_tol + 2))
                                       - int'(cfg_tol) - 1);
            end else begin
                ang = 16'($urandom);
            end
            queue_report(idx, $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 15,
                         run, rdy, ang, 16'($urandom));
        end else if (pick < 80) begin
            if ($urandom_range(0, 19) == 0) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(1, 3000);
            queue_tick(now_ms);
        end else begin
            queue_set(pick < 90 ? IK_SET_ONE : IK_SET_ALL, idx, 16'($urandom),
                      16'($urandom), 16'($urandom));
        end
    endfunction

    task automatic wait_idle();
        while (send_q.size() != 0 || i_in_valid || beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * r);
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_HOME_TARGET: cfg_target = v[15:0];
            REG_HOME_CURRENT: cfg_current = v[15:0];
            REG_HOME_TOL: cfg_tol = v[14:0];
            REG_HOME_TIMEOUT: cfg_timeout = v;
            default: cfg_fault_en = v[0];
        endcase
    endtask

    task automatic write_all(logic [15:0] tgt, logic [15:0] cur, logic [14:0] tol,
                             logic [31:0] tmo, logic fen);
        write_reg(REG_HOME_TARGET, {16'h0, tgt});
        write_reg(REG_HOME_CURRENT, {16'h0, cur});
        write_reg(REG_HOME_TOL, {17'h0, tol});
        write_reg(REG_HOME_TIMEOUT, tmo);
        write_reg(REG_FAULT_EN, {31'h0, fen});
    endtask

    task automatic run_phase(int n, int s_idle, int r_stall);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        for (int k = 0; k < n; k++) begin
            queue_random_item();
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= send_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt <= 400;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (beats_due.size() == 0) begin
                $error("unexpected beat %p", o_out_data);
                errors++;
            end else begin
                want = beats_due.pop_front();
                if (o_out_data.result_kind !== want.result_kind) begin
                    $error("result_kind exp %0d got %0d", want.result_kind,
                           o_out_data.result_kind);
                    errors++;
                end
                if (o_out_data.target_motor !== want.target_motor) begin
                    $error("target_motor exp %0d got %0d", want.target_motor,
                           o_out_data.target_motor);
                    errors++;
                end
                if (o_out_data.position_target !== want.position_target) begin
                    $error("position_target exp %0d got %0d", want.position_target,
                           o_out_data.position_target);
                    errors++;
                end
                if (o_out_data.speed_target !== want.speed_target) begin
                    $error("speed_target exp %0d got %0d", want.speed_target,
                           o_out_data.speed_target);
                    errors++;
                end
                if (o_out_data.current_target !== want.current_target) begin
                    $error("current_target exp %0d got %0d", want.current_target,
                           o_out_data.current_target);
                    errors++;
                end
                if (o_out_data.group_state !== want.group_state) begin
                    $error("group_state exp %0d got %0d", want.group_state,
                           o_out_data.group_state);
                    errors++;
                end
                if (o_out_data.status_code !== want.status_code) begin
                    $error("status_code exp %0d got %0d", want.status_code,
                           o_out_data.status_code);
                    errors++;
                end
                if (o_out_data.last_result !== want.last_result) begin
                    $error("last_result exp %0d got %0d", want.last_result,
                           o_out_data.last_result);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        cfg_target = RST_HOME_TARGET;
        cfg_current = RST_HOME_CURRENT;
        cfg_tol = RST_HOME_TOL;
        cfg_timeout = RST_HOME_TIMEOUT;
        cfg_fault_en = 1'b0;
        mode = MODE_OFFLINE;
        homed = 1'b0;
        homed_mask = '0;
        calib_start = '0;
        for (int i = 0; i < NMOT; i++) begin
            held_lim[i] = '0;
            saved_valid[i] = 1'b0;
            flags[i] = '0;
            angle[i] = '0;
            cur_lim[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed walk through calibration, running and back to offline.
        queue_report(15, 1, 1, 1, 1, 16'h7FFF, 16'h8000);
        queue_set(IK_SET_ONE, 3, 16'h1234, 16'h0001, 16'h0002);
        queue_set(IK_SET_ONE, 12, 16'h1234, 16'h0001, 16'h0002);
        queue_set(IK_SET_ALL, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_tick(32'd0);
        queue_report(0, 1, 0, 1, 1, 16'd23040, 16'h8000);
        queue_report(1, 1, 0, 1, 1, 16'h7FFF, 16'h7FFF);
        queue_report(2, 1, 0, 0, 1, 16'h0000, 16'd100);
        queue_tick(32'd10);
        queue_tick(32'd20);
        queue_tick(32'd30);
        queue_tick(32'd7000);
        queue_tick(32'd7010);
        queue_set(IK_SET_ONE, 1, 16'h8000, 16'h7FFF, 16'h0000);
        queue_set(IK_SET_ALL, 0, 16'hFFFF, 16'h0000, 16'h8000);
        queue_set(IK_SET_ONE, 9, 16'h0001, 16'h0001, 16'h0001);
        queue_report(0, 1, 1, 0, 1, 16'h8000, 16'h0000);
        queue_report(1, 1, 0, 0, 0, 16'h0000, 16'h0000);
        queue_tick(32'hFFFF_FFFF);
        queue_report(0, 0, 0, 0, 0, 16'h0000, 16'h0000);
        queue_report(1, 0, 0, 0, 0, 16'h0000, 16'h0000);
        queue_report(2, 0, 0, 0, 0, 16'h0000, 16'h0000);
        queue_tick(32'd5);
        now_ms = 32'd100;
        wait_idle();

        write_all(16'h8000, 16'h7FFF, 15'd0, 32'd0, 1'b1);
        run_phase(90, 0, 0);
        hold_go <= 1'b1;
        run_phase(90, 0, 0);
        write_all(16'h7FFF, 16'h8000, 15'h7FFF, 32'hFFFF_FFFF, 1'b0);
        run_phase(90, 64, 0);
        write_all(16'($urandom), 16'($urandom), 15'($urandom), $urandom_range(0, 5000), 1'b1);
        run_phase(90, 0, 64);
        write_all(RST_HOME_TARGET, RST_HOME_CURRENT, RST_HOME_TOL, RST_HOME_TIMEOUT, 1'b1);
        run_phase(90, 38, 38);
        repeat (30) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
